>>> rtl/sbox_feistel_block_cipher_cbc_defines.svh
// Assertion macros shared by the cipher RTL.
`ifndef SBOX_FEISTEL_BLOCK_CIPHER_CBC_DEFINES_SVH
`define SBOX_FEISTEL_BLOCK_CIPHER_CBC_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SFBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SFBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sfbc_pkg.sv
`timescale 1ns / 1ps

package sfbc_pkg;

    localparam int WORD_W       = 32;
    localparam int HALF_W       = 2 * WORD_W;
    localparam int BLK_W        = 4 * WORD_W;
    localparam int ROT_BITS     = 8;
    localparam int ROT_BACK     = 24;
    localparam int HALF_STEPS   = 16;
    localparam int STEP_W       = $clog2(HALF_STEPS);
    localparam int KIND_W       = 2;
    localparam int INDEX_W      = 9;

    // Item kinds carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_SEED = 2'd1,
        KIND_ENC  = 2'd2,
        KIND_DEC  = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ISSUE = 3'd1,
        ST_MIX   = 3'd2,
        ST_FIN   = 3'd3
    } t_state;

    // Rotate a 64-bit half left by one byte
    function automatic logic [HALF_W-1:0] rotl_half(input logic [HALF_W-1:0] x);
        return {x[HALF_W-ROT_BITS-1:0], x[HALF_W-1:HALF_W-ROT_BITS]};
    endfunction

    // Rotate a 64-bit half right by one byte; low word moves up by ROT_BACK
    function automatic logic [HALF_W-1:0] rotr_half(input logic [HALF_W-1:0] x);
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        hi = x[HALF_W-1:WORD_W];
        lo = x[WORD_W-1:0];
        return {(hi >> ROT_BITS) | (lo << ROT_BACK), (lo >> ROT_BITS) | (hi << ROT_BACK)};
    endfunction

endpackage

>>> rtl/sbox_feistel_block_cipher_cbc.sv
`timescale 1ns / 1ps
`include "sbox_feistel_block_cipher_cbc_defines.svh"

// 128-bit two-S-box Feistel cipher with optional CBC chaining. Load items
// (tuser kind 0) write one S-box entry when accepted; the S-boxes hold
// no defined value until loaded. Seed, encrypt and decrypt items are accepted,
// then run sixteen half-steps of issue (registered S-box read, decrypt byte
// rotation) and mix (XOR, encrypt byte rotation), then settle chaining.
// That read-then-mix loop through the two S-box RAMs sets the rate; the block
// takes no new item while it runs. A finished result waits in the output
// register, so the next item may start while it is still unclaimed; a result
// only stalls completion if the previous one has not yet been taken.
// Chaining is controlled by the one-bit register on the cfg channel (reset 1).
module sbox_feistel_block_cipher_cbc #(
    parameter int BOX_ENTRIES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config: chaining_on
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sbox_index[8:0], sbox_value[40:9], salt[72:41], in_word0[104:73],
    // in_word1[136:105], in_word2[168:137], in_word3[200:169], zero fill
    input  logic [207:0] s_axis_tdata,
    // kind[1:0]
    input  logic [sfbc_pkg::KIND_W-1:0] s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_word0[31:0], out_word1[63:32], out_word2[95:64], out_word3[127:96]
    output logic [127:0] m_axis_tdata
);

    import sfbc_pkg::*;

    localparam int AW = $clog2(BOX_ENTRIES);

    // tdata field offsets
    localparam int IDX_LSB  = 0;
    localparam int VAL_LSB  = IDX_LSB + INDEX_W;
    localparam int SALT_LSB = VAL_LSB + WORD_W;
    localparam int W0_LSB   = SALT_LSB + WORD_W;
    localparam int W1_LSB   = W0_LSB + WORD_W;
    localparam int W2_LSB   = W1_LSB + WORD_W;
    localparam int W3_LSB   = W2_LSB + WORD_W;

    // Block layout inside: {w0, w1, w2, w3}; half 0 = {w0, w1}
    t_state              r_state,     n_state;
    t_kind               r_kind,      n_kind;
    logic [STEP_W-1:0]   r_step,      n_step;
    logic [BLK_W-1:0]    r_blk,       n_blk;
    logic [BLK_W-1:0]    r_orig,      n_orig;
    logic [BLK_W-1:0]    r_enc_chain, n_enc_chain;
    logic [BLK_W-1:0]    r_dec_chain, n_dec_chain;
    logic                r_chain_on;
    logic                r_out_valid, n_out_valid;
    logic [BLK_W-1:0]    r_out_data,  n_out_data;

    logic                dec_mode;
    logic                src_is_h0;
    logic [HALF_W-1:0]   src_cur;
    logic [HALF_W-1:0]   dst_cur;
    logic [HALF_W-1:0]   src_a;
    logic [HALF_W-1:0]   src_new;
    logic [HALF_W-1:0]   dst_new;
    logic [BLK_W-1:0]    in_blk;
    logic [BLK_W-1:0]    seed_blk;
    logic [BLK_W-1:0]    fin_blk;
    logic                is_result;
    logic                accept;

    logic                ram1_we, ram2_we;
    logic [AW-1:0]       ram1_addr, ram2_addr;
    logic [WORD_W-1:0]   ram1_rdata, ram2_rdata;

    t_kind               in_kind;

    assign in_kind = t_kind'(s_axis_tuser);
    assign accept  = s_axis_tvalid && s_axis_tready;

    assign in_blk   = {s_axis_tdata[W0_LSB +: WORD_W], s_axis_tdata[W1_LSB +: WORD_W],
                       s_axis_tdata[W2_LSB +: WORD_W], s_axis_tdata[W3_LSB +: WORD_W]};
    assign seed_blk = {s_axis_tdata[SALT_LSB +: WORD_W], {(BLK_W-WORD_W){1'b0}}};

    // Pick the source and destination halves of the current half-step
    assign dec_mode  = (r_kind == KIND_DEC);
    assign src_is_h0 = r_step[0] ^ dec_mode;
    assign src_cur   = src_is_h0 ? r_blk[BLK_W-1:HALF_W] : r_blk[HALF_W-1:0];
    assign dst_cur   = src_is_h0 ? r_blk[HALF_W-1:0]     : r_blk[BLK_W-1:HALF_W];

    // Decrypt rotates the source before the lookup, encrypt after the mix
    assign src_a   = dec_mode ? rotr_half(src_cur) : src_cur;
    assign src_new = dec_mode ? src_cur : rotl_half(src_cur);
    assign dst_new = dst_cur ^ {ram1_rdata, ram2_rdata};

    assign fin_blk   = (dec_mode && r_chain_on) ? (r_blk ^ r_dec_chain) : r_blk;
    assign is_result = (r_kind == KIND_ENC) || (r_kind == KIND_DEC);

    // S-box RAM control: load writes in idle, lookups in the issue cycle
    always_comb begin
        ram1_we   = 1'b0;
        ram2_we   = 1'b0;
        ram1_addr = src_a[WORD_W +: AW];
        ram2_addr = src_a[0 +: AW];
        if (r_state == ST_IDLE) begin
            ram1_addr = s_axis_tdata[IDX_LSB +: AW];
            ram2_addr = s_axis_tdata[IDX_LSB +: AW];
            if (accept && in_kind == KIND_LOAD) begin
                ram1_we = !s_axis_tdata[IDX_LSB + INDEX_W - 1];
                ram2_we =  s_axis_tdata[IDX_LSB + INDEX_W - 1];
            end
        end
    end

    sfbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BOX_ENTRIES)
    ) u_box_one (
        .i_clk   (i_clk),
        .i_we    (ram1_we),
        .i_addr  (ram1_addr),
        .i_wdata (s_axis_tdata[VAL_LSB +: WORD_W]),
        .o_rdata (ram1_rdata)
    );

    sfbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BOX_ENTRIES)
    ) u_box_two (
        .i_clk   (i_clk),
        .i_we    (ram2_we),
        .i_addr  (ram2_addr),
        .i_wdata (s_axis_tdata[VAL_LSB +: WORD_W]),
        .o_rdata (ram2_rdata)
    );

    // Sequencer: next state, block datapath, chaining and output register
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_step      = r_step;
        n_blk       = r_blk;
        n_orig      = r_orig;
        n_enc_chain = r_enc_chain;
        n_dec_chain = r_dec_chain;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            ST_IDLE: begin
                if (accept && in_kind != KIND_LOAD) begin
                    n_kind  = in_kind;
                    n_step  = '0;
                    n_orig  = in_blk;
                    n_state = ST_ISSUE;
                    case (in_kind)
                        KIND_SEED: n_blk = r_chain_on ? (seed_blk ^ r_enc_chain) : seed_blk;
                        KIND_ENC:  n_blk = r_chain_on ? (in_blk ^ r_enc_chain) : in_blk;
                        default:   n_blk = in_blk;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (src_is_h0) begin
                    n_blk[BLK_W-1:HALF_W] = src_a;
                end else begin
                    n_blk[HALF_W-1:0] = src_a;
                end
                n_state = ST_MIX;
            end
            ST_MIX: begin
                if (src_is_h0) begin
                    n_blk = {src_new, dst_new};
                end else begin
                    n_blk = {dst_new, src_new};
                end
                n_step  = r_step + STEP_W'(1);
                n_state = (r_step == STEP_W'(HALF_STEPS - 1)) ? ST_FIN : ST_ISSUE;
            end
            ST_FIN: begin
                if (!(is_result && r_out_valid && !m_axis_tready)) begin
                    n_state = ST_IDLE;
                    case (r_kind)
                        KIND_SEED: begin
                            n_enc_chain = r_blk;
                            n_dec_chain = r_blk;
                        end
                        KIND_ENC: begin
                            if (r_chain_on) begin
                                n_enc_chain = r_blk;
                            end
                        end
                        KIND_DEC: begin
                            if (r_chain_on) begin
                                n_dec_chain = r_orig;
                            end
                        end
                        default: begin
                            n_enc_chain = r_enc_chain;
                        end
                    endcase
                    if (is_result) begin
                        n_out_valid = 1'b1;
                        n_out_data  = fin_blk;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and chaining registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_LOAD;
            r_step      <= '0;
            r_enc_chain <= '0;
            r_dec_chain <= '0;
            r_chain_on  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_step      <= n_step;
            r_enc_chain <= n_enc_chain;
            r_dec_chain <= n_dec_chain;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_chain_on <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_blk      <= n_blk;
        r_orig     <= n_orig;
        r_out_data <= n_out_data;
    end

    // Refuse items and config writes while held in reset
    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_data[WORD_W-1:0],
                            r_out_data[2*WORD_W-1:WORD_W],
                            r_out_data[3*WORD_W-1:2*WORD_W],
                            r_out_data[4*WORD_W-1:3*WORD_W]};

    `SFBC_ASSERT_NEXT(a_issue_then_mix, i_clk, i_rst_n, r_state == ST_ISSUE,
                      r_state == ST_MIX, "issue not followed by mix")
    `SFBC_ASSERT_NEXT(a_last_step_fin, i_clk, i_rst_n,
                      (r_state == ST_MIX) && (r_step == STEP_W'(HALF_STEPS - 1)),
                      r_state == ST_FIN, "last half-step did not finish")
    `SFBC_ASSERT_SAME(a_result_from_fin, i_clk, i_rst_n, $rose(m_axis_tvalid),
                      $past(r_state) == ST_FIN, "result raised outside completion")
    `SFBC_ASSERT_SAME(a_load_only_idle, i_clk, i_rst_n, ram1_we || ram2_we,
                      (r_state == ST_IDLE) && !(ram1_we && ram2_we),
                      "S-box write outside idle or to both boxes")

endmodule

>>> rtl/sfbc_ram.sv
`timescale 1ns / 1ps

module sfbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
